// ===== rtl/esc_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the sensor compensation block.
package esc_pkg;

  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temp_centi_c;
    logic signed [15:0] temp_centi_f;
    logic [16:0]        hum_q22_10;
    logic [16:0]        hum_milli_pct;
    logic [16:0]        press_pa;
    logic [19:0]        press_milli_mmhg;
  } out_t;

  typedef struct packed {
    s32_t t1, t2, t3;
    s32_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
    s32_t h1, h2, h3, h4, h5, h6;
  } coef_t;

  localparam int DivBits = 32;

  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_9 = 3'd3;
  localparam logic [2:0] REG_HUM     = 3'd4;

  // signed divide by 2**k, truncating toward zero
  function automatic s32_t sdiv_p2(input s32_t x, input int k);
    s32_t bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic coef_t unpack_coefs(input logic [47:0] tc, input logic [63:0] pa,
                                         input logic [63:0] pb, input logic [15:0] p9,
                                         input logic [63:0] hc);
    coef_t c;
    c.t1 = {16'd0, tc[15:0]};
    c.t2 = {{16{tc[31]}}, tc[31:16]};
    c.t3 = {{16{tc[47]}}, tc[47:32]};
    c.p1 = {16'd0, pa[15:0]};
    c.p2 = {{16{pa[31]}}, pa[31:16]};
    c.p3 = {{16{pa[47]}}, pa[47:32]};
    c.p4 = {{16{pa[63]}}, pa[63:48]};
    c.p5 = {{16{pb[15]}}, pb[15:0]};
    c.p6 = {{16{pb[31]}}, pb[31:16]};
    c.p7 = {{16{pb[47]}}, pb[47:32]};
    c.p8 = {{16{pb[63]}}, pb[63:48]};
    c.p9 = {{16{p9[15]}}, p9};
    c.h1 = {24'd0, hc[7:0]};
    c.h2 = {{16{hc[23]}}, hc[23:8]};
    c.h3 = {24'd0, hc[31:24]};
    c.h4 = {{20{hc[43]}}, hc[43:32]};
    c.h5 = {{20{hc[55]}}, hc[55:44]};
    c.h6 = {{24{hc[63]}}, hc[63:56]};
    return c;
  endfunction

endpackage

// ===== rtl/esc_delay.sv =====
// Enabled shift line that delays a word through Depth registers.
module esc_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [Width-1:0] din,
  output logic [Width-1:0] dout
);

  logic [Width-1:0] taps [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < Depth; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[Depth-1];

endmodule

// ===== rtl/esc_temp.sv =====
// Temperature pipeline: fine temperature, centi-degrees C and F.
module esc_temp (
  input  logic                clk,
  input  logic                en,
  input  esc_pkg::coef_t      coefs,
  input  logic [19:0]         raw_temp,
  output esc_pkg::s32_t       tf,
  output logic signed [14:0]  tc,
  output logic signed [15:0]  tfa
);

  esc_pkg::s32_t a1, b1, am, bb, a3, bm, tf4;
  esc_pkg::s32_t t5_sum, t5_div;
  logic signed [14:0] tc5, tc6, tc7;
  logic signed [18:0] v6;
  logic [17:0] mag6;
  logic [35:0] prod6;
  logic neg6;
  logic signed [15:0] tfa7;

  always_comb begin
    t5_sum = (tf4 <<< 2) + tf4 + 32'sd128;
    t5_div = esc_pkg::sdiv_p2(t5_sum, 8);
    v6     = 19'(tc5) * 19'sd18 + 19'sd32000;
    mag6   = v6[18] ? 18'(-v6) : v6[17:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= $signed({15'd0, raw_temp[19:3]}) - (coefs.t1 <<< 1);
      b1   <= $signed({16'd0, raw_temp[19:4]}) - coefs.t1;
      am   <= a1 * coefs.t2;
      bb   <= b1 * b1;
      a3   <= esc_pkg::sdiv_p2(am, 11);
      bm   <= esc_pkg::sdiv_p2(bb, 12) * coefs.t3;
      tf4  <= a3 + esc_pkg::sdiv_p2(bm, 14);
      if (t5_div < -32'sd4000) begin
        tc5 <= -15'sd4000;
      end else if (t5_div > 32'sd8500) begin
        tc5 <= 15'sd8500;
      end else begin
        tc5 <= t5_div[14:0];
      end
      prod6 <= 36'(mag6) * 36'd209716;
      neg6  <= v6[18];
      tc6   <= tc5;
      tfa7  <= neg6 ? -$signed({1'b0, prod6[35:21]}) : $signed({1'b0, prod6[35:21]});
      tc7   <= tc6;
    end
  end

  assign tf  = tf4;
  assign tc  = tc7;
  assign tfa = tfa7;

endmodule

// ===== rtl/esc_hum.sv =====
// Humidity pipeline: Q22.10 humidity and milli-percent.
module esc_hum (
  input  logic           clk,
  input  logic           en,
  input  esc_pkg::coef_t coefs,
  input  esc_pkg::s32_t  tf,
  input  logic [15:0]    raw_hum,
  output logic [16:0]    hum,
  output logic [16:0]    milli
);

  esc_pkg::s32_t ha, hbc, hd, hm6, hm3, hbc2, he3, hb3, hcc3, he4, hp4, he5, hd5;
  esc_pkg::s32_t he6, hdm6, he7, hb7, hc8, hc9, hsq9, hc10, hdm10, cq9, he11;
  logic [16:0] hum11, hum12, milli12;
  logic [26:0] prodm;

  always_comb begin
    cq9  = esc_pkg::sdiv_p2(hc8, 15);
    he11 = hc10 - esc_pkg::sdiv_p2(hdm10, 4);
    prodm = 27'(hum11) * 27'd1000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha    <= tf - 32'sd76800;
      hbc   <= $signed({2'd0, raw_hum, 14'd0}) - (coefs.h4 <<< 20);
      hd    <= coefs.h5 * ha;
      hm6   <= ha * coefs.h6;
      hm3   <= ha * coefs.h3;
      hbc2  <= hbc;
      he3   <= esc_pkg::sdiv_p2(hbc2 - hd + 32'sd16384, 15);
      hb3   <= esc_pkg::sdiv_p2(hm6, 10);
      hcc3  <= esc_pkg::sdiv_p2(hm3, 11) + 32'sd32768;
      hp4   <= hb3 * hcc3;
      he4   <= he3;
      hd5   <= esc_pkg::sdiv_p2(hp4, 10) + 32'sd2097152;
      he5   <= he4;
      hdm6  <= hd5 * coefs.h2;
      he6   <= he5;
      hb7   <= esc_pkg::sdiv_p2(hdm6 + 32'sd8192, 14);
      he7   <= he6;
      hc8   <= he7 * hb7;
      hsq9  <= cq9 * cq9;
      hc9   <= hc8;
      hdm10 <= esc_pkg::sdiv_p2(hsq9, 7) * coefs.h1;
      hc10  <= hc9;
      if (he11 < 32'sd0) begin
        hum11 <= 17'd0;
      end else if (he11 > 32'sd419430400) begin
        hum11 <= 17'd102400;
      end else begin
        hum11 <= he11[28:12];
      end
      hum12   <= hum11;
      milli12 <= prodm[26:10];
    end
  end

  assign hum   = hum12;
  assign milli = milli12;

endmodule

// ===== rtl/esc_press_pre.sv =====
// Pressure front end: divisor and dividend ahead of the long division.
module esc_press_pre (
  input  logic           clk,
  input  logic           en,
  input  esc_pkg::coef_t coefs,
  input  esc_pkg::s32_t  tf,
  input  logic [19:0]    raw_press,
  output logic [31:0]    num,
  output logic [31:0]    dvs,
  output logic           hi,
  output logic           zero
);

  esc_pkg::s32_t a0, pa1, pq1, psq2, pm5, pm2, pb3, pq3, pm5x3, pd3;
  esc_pkg::s32_t pb4, pc4, pm5x4, pd4, pb5, pc5, pd5, paa6, pb6, pam7, pb7, pdv8, pdv9;
  logic [31:0] pu8, pu9, num10, dvs10;
  logic hi10, zero10;
  logic [19:0] adc_d [7];

  assign a0 = esc_pkg::sdiv_p2(tf, 1) - 32'sd64000;

  always_ff @(posedge clk) begin
    if (en) begin
      pa1   <= a0;
      pq1   <= esc_pkg::sdiv_p2(a0, 2);
      adc_d[0] <= raw_press;
      for (int i = 1; i < 7; i++) begin
        adc_d[i] <= adc_d[i-1];
      end
      psq2  <= pq1 * pq1;
      pm5   <= pa1 * coefs.p5;
      pm2   <= coefs.p2 * pa1;
      pb3   <= esc_pkg::sdiv_p2(psq2, 11);
      pq3   <= esc_pkg::sdiv_p2(psq2, 13);
      pm5x3 <= pm5 <<< 1;
      pd3   <= esc_pkg::sdiv_p2(pm2, 1);
      pb4   <= pb3 * coefs.p6;
      pc4   <= coefs.p3 * pq3;
      pm5x4 <= pm5x3;
      pd4   <= pd3;
      pb5   <= esc_pkg::sdiv_p2(pb4 + pm5x4, 2) + (coefs.p4 <<< 16);
      pc5   <= esc_pkg::sdiv_p2(pc4, 3);
      pd5   <= pd4;
      paa6  <= esc_pkg::sdiv_p2(pc5 + pd5, 18) + 32'sd32768;
      pb6   <= pb5;
      pam7  <= paa6 * coefs.p1;
      pb7   <= pb6;
      pdv8  <= esc_pkg::sdiv_p2(pam7, 15);
      pu8   <= 32'd1048576 - {12'd0, adc_d[6]} - esc_pkg::sdiv_p2(pb7, 12);
      pu9   <= pu8 * 32'd3125;
      pdv9  <= pdv8;
      num10  <= pu9[31] ? pu9 : {pu9[30:0], 1'b0};
      hi10   <= pu9[31];
      dvs10  <= pdv9;
      zero10 <= (pdv9 == 32'sd0);
    end
  end

  assign num  = num10;
  assign dvs  = dvs10;
  assign hi   = hi10;
  assign zero = zero10;

endmodule

// ===== rtl/esc_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module esc_udiv (
  input  logic                        clk,
  input  logic                        en,
  input  logic [esc_pkg::DivBits-1:0] num,
  input  logic [esc_pkg::DivBits-1:0] dvs,
  output logic [esc_pkg::DivBits-1:0] quo
);

  localparam int W = esc_pkg::DivBits;

  logic [W-1:0] rem [W];
  logic [W-1:0] nq  [W];
  logic [W-1:0] dv  [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0] rem_in, nq_in, dv_in;
    logic [W:0]   trial, diff;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign dv_in  = dvs;
    end else begin : g_next
      assign rem_in = rem[s-1];
      assign nq_in  = nq[s-1];
      assign dv_in  = dv[s-1];
    end

    assign trial = {rem_in, nq_in[W-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign ge    = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? diff[W-1:0] : trial[W-1:0];
        nq[s]  <= {nq_in[W-2:0], ge};
        dv[s]  <= dv_in;
      end
    end
  end

  assign quo = nq[W-1];

endmodule

// ===== rtl/esc_press_post.sv =====
// Pressure back end: correction terms, clamp and conversion to milli-mmHg.
module esc_press_post (
  input  logic           clk,
  input  logic           en,
  input  esc_pkg::coef_t coefs,
  input  logic [31:0]    quo,
  input  logic           hi,
  input  logic           zero,
  output logic [16:0]    pa,
  output logic [19:0]    mmhg
);

  logic [31:0] pu1, pu2, pu3, ps2, pr4;
  logic z1, z2, z3, z4;
  esc_pkg::s32_t pm8, pc9, pd3, e4;
  logic [16:0] pa5, pa6, pa7, pa8;
  logic [43:0] prod6;
  logic [19:0] q0, q7, mm8;
  logic [37:0] rem_full;
  logic [18:0] rem7;

  always_comb begin
    e4 = esc_pkg::sdiv_p2(esc_pkg::sdiv_p2(pc9, 12) + pd3 + coefs.p7, 4);
    q0 = prod6[43:24];
    rem_full = 38'(pa6) * 38'd1000000 - 38'(q0) * 38'd133322;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu1 <= hi ? {quo[30:0], 1'b0} : quo;
      z1  <= zero;
      ps2 <= {3'd0, pu1[31:3]} * {3'd0, pu1[31:3]};
      pm8 <= $signed({2'd0, pu1[31:2]}) * coefs.p8;
      pu2 <= pu1;
      z2  <= z1;
      pc9 <= coefs.p9 * $signed({13'd0, ps2[31:13]});
      pd3 <= esc_pkg::sdiv_p2(pm8, 13);
      pu3 <= pu2;
      z3  <= z2;
      pr4 <= pu3 + e4;
      z4  <= z3;
      if (z4 || pr4 < 32'd30000) begin
        pa5 <= 17'd30000;
      end else if (pr4 > 32'd110000) begin
        pa5 <= 17'd110000;
      end else begin
        pa5 <= pr4[16:0];
      end
      prod6 <= 44'(pa5) * 44'd125839816;
      pa6   <= pa5;
      q7    <= q0;
      rem7  <= rem_full[18:0];
      pa7   <= pa6;
      mm8   <= (rem7 >= 19'd133322) ? q7 + 20'd1 : q7;
      pa8   <= pa7;
    end
  end

  assign pa   = pa8;
  assign mmhg = mm8;

endmodule

// ===== rtl/env_sensor_compensation_top.sv =====
// Top level of the environmental sensor compensation pipeline.
//
//  port group   | dir | payload          | handshake
//  in_*         | in  | esc_pkg::in_t    | in_valid / in_ready
//  out_*        | out | esc_pkg::out_t   | out_valid / out_ready
//  p*           | i/o | 64-bit data bus  | APB read/write, pready tied high
//
// One item per cycle while the output is not stalled; the 32-stage divider is the deepest part.
// The whole pipeline advances together; a result left waiting at the output
// freezes every stage until it is taken, and in_ready falls with it.
// Reset clears the valid bits and the coefficient registers.
module env_sensor_compensation_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  esc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output esc_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int TfLat    = 4;
  localparam int TempLat  = 7;
  localparam int HumLat   = 12;
  localparam int PreLat   = 10;
  localparam int PostLat  = 8;
  localparam int TotalLat = TfLat + PreLat + esc_pkg::DivBits + PostLat;

  logic [47:0] temp_coefs;
  logic [63:0] press_coefs_a, press_coefs_b, hum_coefs;
  logic [15:0] press_coef_nine;
  esc_pkg::coef_t coefs;

  logic en;
  logic [TotalLat-1:0] vld;

  esc_pkg::s32_t tf;
  logic signed [14:0] tc, tc_d;
  logic signed [15:0] tfa, tfa_d;
  logic [15:0] raw_hum_d;
  logic [19:0] raw_press_d;
  logic [16:0] hum, milli, hum_d, milli_d, pa;
  logic [19:0] mmhg;
  logic [31:0] num, dvs, quo;
  logic hi, zero, hi_d, zero_d;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coefs      <= '0;
      press_coefs_a   <= '0;
      press_coefs_b   <= '0;
      press_coef_nine <= '0;
      hum_coefs       <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[5:3])
        esc_pkg::REG_TEMP:    temp_coefs      <= pwdata[47:0];
        esc_pkg::REG_PRESS_A: press_coefs_a   <= pwdata;
        esc_pkg::REG_PRESS_B: press_coefs_b   <= pwdata;
        esc_pkg::REG_PRESS_9: press_coef_nine <= pwdata[15:0];
        esc_pkg::REG_HUM:     hum_coefs       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      esc_pkg::REG_TEMP:    prdata = {16'd0, temp_coefs};
      esc_pkg::REG_PRESS_A: prdata = press_coefs_a;
      esc_pkg::REG_PRESS_B: prdata = press_coefs_b;
      esc_pkg::REG_PRESS_9: prdata = {48'd0, press_coef_nine};
      esc_pkg::REG_HUM:     prdata = hum_coefs;
      default:              prdata = '0;
    endcase
  end

  assign coefs = esc_pkg::unpack_coefs(temp_coefs, press_coefs_a, press_coefs_b,
                                       press_coef_nine, hum_coefs);

  assign en        = !vld[TotalLat-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[TotalLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TotalLat-2:0], in_valid};
    end
  end

  esc_temp u_temp (
    .clk(clk), .en(en), .coefs(coefs), .raw_temp(in_data.raw_temp),
    .tf(tf), .tc(tc), .tfa(tfa)
  );

  esc_delay #(.Width(16), .Depth(TfLat)) u_dly_hum_raw (
    .clk(clk), .en(en), .din(in_data.raw_hum), .dout(raw_hum_d)
  );

  esc_delay #(.Width(20), .Depth(TfLat)) u_dly_press_raw (
    .clk(clk), .en(en), .din(in_data.raw_press), .dout(raw_press_d)
  );

  esc_hum u_hum (
    .clk(clk), .en(en), .coefs(coefs), .tf(tf), .raw_hum(raw_hum_d),
    .hum(hum), .milli(milli)
  );

  esc_press_pre u_pre (
    .clk(clk), .en(en), .coefs(coefs), .tf(tf), .raw_press(raw_press_d),
    .num(num), .dvs(dvs), .hi(hi), .zero(zero)
  );

  esc_udiv u_div (
    .clk(clk), .en(en), .num(num), .dvs(dvs), .quo(quo)
  );

  esc_delay #(.Width(2), .Depth(esc_pkg::DivBits)) u_dly_flags (
    .clk(clk), .en(en), .din({hi, zero}), .dout({hi_d, zero_d})
  );

  esc_press_post u_post (
    .clk(clk), .en(en), .coefs(coefs), .quo(quo), .hi(hi_d), .zero(zero_d),
    .pa(pa), .mmhg(mmhg)
  );

  esc_delay #(.Width(31), .Depth(TotalLat - TempLat)) u_dly_temp (
    .clk(clk), .en(en), .din({tc, tfa}), .dout({tc_d, tfa_d})
  );

  esc_delay #(.Width(34), .Depth(TotalLat - TfLat - HumLat)) u_dly_hum (
    .clk(clk), .en(en), .din({hum, milli}), .dout({hum_d, milli_d})
  );

  always_comb begin
    out_data.temp_centi_c     = tc_d;
    out_data.temp_centi_f     = tfa_d;
    out_data.hum_q22_10       = hum_d;
    out_data.hum_milli_pct    = milli_d;
    out_data.press_pa         = pa;
    out_data.press_milli_mmhg = mmhg;
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (vld == $past(vld)))
    else $error("pipeline moved while the output was stalled");

  a_press_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.press_pa >= 17'd30000 && out_data.press_pa <= 17'd110000))
    else $error("pressure outside clamp range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temp_centi_c >= -15'sd4000 && out_data.temp_centi_c <= 15'sd8500))
    else $error("temperature outside clamp range");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hum_q22_10 <= 17'd102400))
    else $error("humidity above full scale");

endmodule
